// ===== src/mphe_pkg.sv =====
// Shared constants, types and state codes of the modular Horner evaluator.
package mphe_pkg;

  localparam int VALUE_BITS = 31;
  localparam int DATA_BITS  = ((VALUE_BITS + 7) / 8) * 8;
  localparam int CNT_BITS   = $clog2(VALUE_BITS);

  localparam logic [CNT_BITS-1:0]   CNT_TOP   = CNT_BITS'(VALUE_BITS - 1);
  localparam logic [VALUE_BITS-1:0] MOD_RESET = VALUE_BITS'(64'd2147483647);

  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MODULUS    = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_EVAL_POINT = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RED_ACC,
    ST_RED_PT,
    ST_RED_COEF,
    ST_MUL,
    ST_ADD
  } state_e;

  // Control of one modular step: u = ((dbl ? 2r+bit : r) mod m + (add_en ? b : 0)) mod m
  typedef struct packed {
    logic dbl;
    logic bit_in;
    logic add_en;
  } step_ctrl_t;

endpackage

// ===== src/mphe_step.sv =====
// Shared modular step unit: optional doubling with a shifted-in bit, then a modular add.
module mphe_step (
  input  mphe_pkg::step_ctrl_t               ctrl_i,
  input  logic [mphe_pkg::VALUE_BITS-1:0]    r_i,
  input  logic [mphe_pkg::VALUE_BITS-1:0]    addend_i,
  input  logic [mphe_pkg::VALUE_BITS-1:0]    mod_i,
  output logic [mphe_pkg::VALUE_BITS-1:0]    u_o
);

  logic [mphe_pkg::VALUE_BITS:0] dbl_v;
  logic [mphe_pkg::VALUE_BITS:0] red_v;
  logic [mphe_pkg::VALUE_BITS:0] sum_v;
  logic [mphe_pkg::VALUE_BITS:0] mod_w;

  assign mod_w = {1'b0, mod_i};

  // r < m, so 2r+bit < 2m and one conditional subtract suffices
  assign dbl_v = ctrl_i.dbl ? {r_i, ctrl_i.bit_in} : {1'b0, r_i};
  assign red_v = (dbl_v >= mod_w) ? (dbl_v - mod_w) : dbl_v;

  // red_v < m, so its top bit is clear and the sum stays below 2m
  assign sum_v = red_v + (ctrl_i.add_en ? {1'b0, addend_i} : '0);

  always_comb begin
    if (sum_v >= mod_w) begin
      u_o = mphe_pkg::VALUE_BITS'(sum_v - mod_w);
    end else begin
      u_o = sum_v[mphe_pkg::VALUE_BITS-1:0];
    end
  end

endmodule

// ===== src/modular_polynomial_horner_eval_unit.sv =====
// Top level of the modular Horner polynomial evaluator with its sequencer.
//
// Channel   Direction  Handshake                  Payload
// s_axis    in         s_axis_tvalid/tready       tdata: coefficient; tlast: final_coef
// m_axis    out        m_axis_tvalid/tready       tdata: poly_value; tuser: range_error
// cfg       in         cfg_valid_i/cfg_ready_o    cfg_index_i, cfg_data_i (0 modulus, 1 point)
//
// Each word runs through accept, a check of each of the three operands against the
// modulus, the bit-serial steps of the shared shift-add modular multiplier and one
// modular add. Each operand at or above the modulus is first reduced bit-serially
// on the same shared unit before the multiplier steps begin.
// Reset puts modulus at 2^31-1, point at 0 and clears accumulator and error flag.
// A finished value sits in the output register while the next word is taken; only a
// second result ready before the first is taken holds the sequencer in its add step.
module modular_polynomial_horner_eval_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // slave stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [mphe_pkg::DATA_BITS-1:0]      s_axis_tdata,   // [30:0] coefficient, rest 0
  input  logic                                s_axis_tlast,
  // master stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [mphe_pkg::DATA_BITS-1:0]      m_axis_tdata,   // [30:0] poly_value, rest 0
  output logic                                m_axis_tuser,   // [0] range_error
  // configuration write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [mphe_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  logic [mphe_pkg::VALUE_BITS-1:0]     cfg_data_i
);

  localparam int VB = mphe_pkg::VALUE_BITS;

  mphe_pkg::state_e state_q, state_d;

  // configuration
  logic [VB-1:0] mod_q, point_q;
  logic [VB-1:0] mod_eff;

  // working registers
  logic [VB-1:0] acc_q, acc_d;
  logic [VB-1:0] pt_q, pt_d;
  logic [VB-1:0] coef_q, coef_d;
  logic [VB-1:0] r_q, r_d;
  logic          last_q, last_d;
  logic          err_q, err_d;
  logic [mphe_pkg::CNT_BITS-1:0] cnt_q, cnt_d;

  // output register
  logic          out_valid_q, out_valid_d;
  logic [VB-1:0] out_val_q, out_val_d;
  logic          out_err_q, out_err_d;

  // sequencer decode
  logic          in_fire;
  logic          fresh;
  logic          skip;
  logic          step_last;
  logic          out_block;
  logic [VB-1:0] red_val;

  // shared unit
  mphe_pkg::step_ctrl_t step_ctrl;
  logic [VB-1:0] step_r;
  logic [VB-1:0] step_addend;
  logic [VB-1:0] step_u;

  // a zero modulus behaves as a modulus of one
  assign mod_eff = (mod_q == '0) ? VB'(1) : mod_q;

  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign fresh     = (cnt_q == mphe_pkg::CNT_TOP);
  assign step_last = (cnt_q == '0);
  assign out_block = out_valid_q && !m_axis_tready;

  // operand under reduction
  always_comb begin
    unique case (state_q)
      mphe_pkg::ST_RED_ACC: red_val = acc_q;
      mphe_pkg::ST_RED_PT:  red_val = pt_q;
      default:              red_val = coef_q;
    endcase
  end

  // first cycle of a reduction: operand already below the modulus needs no work
  assign skip = fresh && (red_val < mod_eff);

  // ---------------- next state ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mphe_pkg::ST_IDLE: begin
        if (in_fire) state_d = mphe_pkg::ST_RED_ACC;
      end
      mphe_pkg::ST_RED_ACC: begin
        if (skip || step_last) state_d = mphe_pkg::ST_RED_PT;
      end
      mphe_pkg::ST_RED_PT: begin
        if (skip || step_last) state_d = mphe_pkg::ST_RED_COEF;
      end
      mphe_pkg::ST_RED_COEF: begin
        if (skip || step_last) state_d = mphe_pkg::ST_MUL;
      end
      mphe_pkg::ST_MUL: begin
        if (step_last) state_d = mphe_pkg::ST_ADD;
      end
      mphe_pkg::ST_ADD: begin
        if (!(last_q && out_block)) state_d = mphe_pkg::ST_IDLE;
      end
      default: state_d = mphe_pkg::ST_IDLE;
    endcase
  end

  // ---------------- sequencer outputs ----------------
  always_comb begin
    s_axis_tready = 1'b0;
    step_ctrl     = '0;
    step_r        = fresh ? '0 : r_q;
    step_addend   = pt_q;
    unique case (state_q)
      mphe_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
      end
      mphe_pkg::ST_RED_ACC, mphe_pkg::ST_RED_PT, mphe_pkg::ST_RED_COEF: begin
        // r = (2r + next operand bit) mod m, MSB first
        step_ctrl.dbl    = 1'b1;
        step_ctrl.bit_in = red_val[cnt_q];
      end
      mphe_pkg::ST_MUL: begin
        // r = (2r + acc bit * point) mod m, MSB first
        step_ctrl.dbl    = 1'b1;
        step_ctrl.add_en = acc_q[cnt_q];
      end
      mphe_pkg::ST_ADD: begin
        step_r           = r_q;
        step_addend      = coef_q;
        step_ctrl.add_en = 1'b1;
      end
      default: ;
    endcase
  end

  mphe_step u_step (
    .ctrl_i   (step_ctrl),
    .r_i      (step_r),
    .addend_i (step_addend),
    .mod_i    (mod_eff),
    .u_o      (step_u)
  );

  // ---------------- datapath ----------------
  always_comb begin
    acc_d       = acc_q;
    pt_d        = pt_q;
    coef_d      = coef_q;
    r_d         = r_q;
    last_d      = last_q;
    err_d       = err_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_val_d   = out_val_q;
    out_err_d   = out_err_q;

    unique case (state_q)
      mphe_pkg::ST_IDLE: begin
        if (in_fire) begin
          coef_d = s_axis_tdata[VB-1:0];
          last_d = s_axis_tlast;
          pt_d   = point_q;
          cnt_d  = mphe_pkg::CNT_TOP;
          if (s_axis_tdata[VB-1:0] >= mod_eff) err_d = 1'b1;
        end
      end
      mphe_pkg::ST_RED_ACC, mphe_pkg::ST_RED_PT, mphe_pkg::ST_RED_COEF: begin
        if (!skip) begin
          r_d = step_u;
          if (step_last) begin
            cnt_d = mphe_pkg::CNT_TOP;
            unique case (state_q)
              mphe_pkg::ST_RED_ACC: acc_d  = step_u;
              mphe_pkg::ST_RED_PT:  pt_d   = step_u;
              default:              coef_d = step_u;
            endcase
          end else begin
            cnt_d = cnt_q - 1'b1;
          end
        end
      end
      mphe_pkg::ST_MUL: begin
        r_d   = step_u;
        cnt_d = step_last ? mphe_pkg::CNT_TOP : (cnt_q - 1'b1);
      end
      mphe_pkg::ST_ADD: begin
        if (!last_q) begin
          acc_d = step_u;
        end else if (!out_block) begin
          // end of polynomial: hand off the value and start over
          out_valid_d = 1'b1;
          out_val_d   = step_u;
          out_err_d   = err_q;
          acc_d       = '0;
          err_d       = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mphe_pkg::ST_IDLE;
      mod_q       <= mphe_pkg::MOD_RESET;
      point_q     <= '0;
      acc_q       <= '0;
      err_q       <= 1'b0;
      cnt_q       <= mphe_pkg::CNT_TOP;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      acc_q       <= acc_d;
      err_q       <= err_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          mphe_pkg::CFG_MODULUS:    mod_q   <= cfg_data_i;
          mphe_pkg::CFG_EVAL_POINT: point_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    pt_q      <= pt_d;
    coef_q    <= coef_d;
    r_q       <= r_d;
    last_q    <= last_d;
    out_val_q <= out_val_d;
    out_err_q <= out_err_d;
  end

  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = mphe_pkg::DATA_BITS'(out_val_q);
  assign m_axis_tuser  = out_err_q;

`ifndef NO_ASSERTIONS
  // multiplier operands are reduced before the shift-add loop runs
  a_mul_operands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mphe_pkg::ST_MUL |-> (acc_q < mod_eff) && (pt_q < mod_eff)
                                    && (coef_q < mod_eff))
    else $error("multiplier operand not reduced");

  // partial product stays below the modulus
  a_partial_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mphe_pkg::ST_ADD |-> r_q < mod_eff)
    else $error("partial product not reduced");

  // a new result only comes out of the add step
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == mphe_pkg::ST_ADD && $past(last_q))
    else $error("result raised outside add step");

  // closing a polynomial clears the running state
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mphe_pkg::ST_ADD && last_q && !out_block) |=> (acc_q == '0) && !err_q)
    else $error("accumulator not cleared after last word");
`endif

endmodule
